/* sv/rdsa_pkg.sv */
// ----------------------------------------------------------------------------
// rdsa_pkg
// shared types and codes for the radix digit string adder
// ----------------------------------------------------------------------------
package rdsa_pkg;

  localparam logic [1:0] OP_SET     = 2'd0;
  localparam logic [1:0] OP_SET_MOD = 2'd1;
  localparam logic [1:0] OP_INC     = 2'd2;

  localparam logic [7:0] CFG_RADIX       = 8'd0;
  localparam logic [7:0] CFG_RANGE_LIMIT = 8'd1;
  localparam logic [7:0] CFG_BASE_DIGITS = 8'd2;
  localparam logic [7:0] CFG_BASE_LENGTH = 8'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [63:0] digit_word;
    logic [3:0]  digit_count;
    logic [63:0] int_value;
    logic        overflow;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

/* sv/radix_digit_string_adder_top.sv */
// ----------------------------------------------------------------------------
// radix_digit_string_adder_top
// little-endian digit string in a configurable radix, set and increment
// ----------------------------------------------------------------------------
// steps: an unknown op goes straight to the finish; increment divides the digit plus one
//   at each position the carry reaches; set divides the value and then the digit sum at
//   each nonzero step, after a range reduction in range mode; one item at a time
// reset: asynchronous active low, string one digit zero, value zero
// results are shown for one cycle on res_valid_o; the receiver cannot stall
module radix_digit_string_adder_top #(
  parameter int MAX_DIGITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rdsa_pkg::cmd_t cmd_i,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_index_i,
  input  logic [63:0]    cfg_data_i,
  output logic           res_valid_o,
  output rdsa_pkg::res_t res_o
);
  import rdsa_pkg::*;

  localparam int         IW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [3:0] MAXL = 4'(MAX_DIGITS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOD, ST_LOAD, ST_CHECK, ST_DX, ST_DS, ST_DI, ST_FIN
  } state_e;

  // configuration registers
  logic [7:0]  radix_q;
  logic [63:0] range_q;
  logic [63:0] base_digits_q;
  logic [3:0]  base_len_q;

  // string state
  logic [7:0]  digit_q [MAX_DIGITS];
  logic [3:0]  len_q;
  logic [63:0] int_q;

  // sequencer
  state_e      state_q;
  logic [63:0] x_q;
  logic [63:0] qhold_q;
  logic [3:0]  i_q;
  logic        ovf_q;
  div_req_t    div_req_q;
  div_rsp_t    div_rsp;
  logic        res_valid_q;
  res_t        res_q;

  logic [7:0]  r_eff;
  logic [3:0]  base_n;
  logic [3:0]  i_nxt;
  logic [63:0] word;

  assign r_eff  = (radix_q < 8'd2) ? 8'd2 : radix_q;
  assign base_n = (base_len_q > MAXL) ? MAXL : base_len_q;
  assign i_nxt  = i_q + 4'd1;

  // pack valid digits, positions past the length read as zero
  always_comb begin
    word = '0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (4'(k) < len_q) word[8*k +: 8] = digit_q[k];
    end
  end

  rdsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // config writes are only taken while no item is in flight
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= 8'd26;
      range_q       <= '1;
      base_digits_q <= '0;
      base_len_q    <= 4'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RADIX:       radix_q       <= cfg_data_i[7:0];
        CFG_RANGE_LIMIT: range_q       <= cfg_data_i;
        CFG_BASE_DIGITS: base_digits_q <= cfg_data_i;
        CFG_BASE_LENGTH: base_len_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      res_valid_q     <= 1'b0;
      div_req_q.start <= 1'b0;
      for (int k = 0; k < MAX_DIGITS; k++) digit_q[k] <= '0;
      len_q           <= 4'd1;
      int_q           <= '0;
      i_q             <= '0;
      ovf_q           <= 1'b0;
    end else begin
      res_valid_q     <= 1'b0;
      div_req_q.start <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            ovf_q <= 1'b0;
            i_q   <= '0;
            x_q   <= cmd_i.amount;
            case (cmd_i.op)
              OP_SET: state_q <= ST_LOAD;
              OP_SET_MOD: begin
                if (range_q != '0) begin
                  // reduce amount by the range limit first
                  div_req_q <= '{start: 1'b1, num: cmd_i.amount, den: range_q};
                  state_q   <= ST_MOD;
                end else begin
                  state_q <= ST_LOAD;
                end
              end
              OP_INC: begin
                int_q <= int_q + 64'd1;
                if (len_q == '0) begin
                  // empty string gets a single digit zero
                  digit_q[0] <= '0;
                  len_q      <= 4'd1;
                  state_q    <= ST_FIN;
                end else begin
                  div_req_q <= '{start: 1'b1,
                                 num: 64'({1'b0, digit_q[0]} + 9'd1),
                                 den: 64'(r_eff)};
                  state_q   <= ST_DI;
                end
              end
              default: state_q <= ST_FIN;
            endcase
          end
        end
        ST_MOD: begin
          if (div_rsp.done) begin
            x_q     <= div_rsp.rem;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          for (int k = 0; k < MAX_DIGITS; k++) begin
            digit_q[k] <= (4'(k) < base_n) ? base_digits_q[8*k +: 8] : 8'd0;
          end
          len_q   <= base_n;
          int_q   <= x_q;
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (x_q == '0) begin
            state_q <= ST_FIN;
          end else if (i_q >= MAXL) begin
            // value left over past the last position is dropped
            ovf_q   <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            div_req_q <= '{start: 1'b1, num: x_q, den: 64'(r_eff)};
            state_q   <= ST_DX;
          end
        end
        ST_DX: begin
          if (div_rsp.done) begin
            qhold_q <= div_rsp.quot;
            if (i_q >= len_q) begin
              // append a zero digit at the end position
              digit_q[i_q[IW-1:0]] <= '0;
              len_q     <= i_nxt;
              div_req_q <= '{start: 1'b1, num: 64'(div_rsp.rem[7:0]),
                             den: 64'(r_eff)};
            end else begin
              div_req_q <= '{start: 1'b1,
                             num: 64'({1'b0, div_rsp.rem[7:0]} +
                                      {1'b0, digit_q[i_q[IW-1:0]]}),
                             den: 64'(r_eff)};
            end
            state_q <= ST_DS;
          end
        end
        ST_DS: begin
          if (div_rsp.done) begin
            digit_q[i_q[IW-1:0]] <= div_rsp.rem[7:0];
            x_q     <= qhold_q + div_rsp.quot;
            i_q     <= i_nxt;
            state_q <= ST_CHECK;
          end
        end
        ST_DI: begin
          if (div_rsp.done) begin
            digit_q[i_q[IW-1:0]] <= div_rsp.rem[7:0];
            if (div_rsp.rem != '0) begin
              state_q <= ST_FIN;
            end else if (i_nxt >= MAXL) begin
              ovf_q   <= 1'b1;
              state_q <= ST_FIN;
            end else if (i_nxt >= len_q) begin
              digit_q[i_nxt[IW-1:0]] <= '0;
              len_q   <= i_nxt + 4'd1;
              state_q <= ST_FIN;
            end else begin
              i_q       <= i_nxt;
              div_req_q <= '{start: 1'b1,
                             num: 64'({1'b0, digit_q[i_nxt[IW-1:0]]} + 9'd1),
                             den: 64'(r_eff)};
            end
          end
        end
        ST_FIN: begin
          res_valid_q       <= 1'b1;
          res_q.digit_word  <= word;
          res_q.digit_count <= len_q;
          res_q.int_value   <= int_q;
          res_q.overflow    <= ovf_q;
          state_q           <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // the strobe lasts exactly one cycle
  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobe held");
  // results only come after the finishing step
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == ST_FIN)) else $error("stray result");
  // the divider is never restarted mid-operation
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |-> !div_rsp.busy) else $error("divider overrun");
  // length never passes the position count
  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.digit_count <= MAXL) else $error("length overrun");
`endif

endmodule

/* sv/rdsa_div.sv */
// ----------------------------------------------------------------------------
// rdsa_div
// shared 64-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rdsa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rdsa_pkg::div_req_t req_i,
  output rdsa_pkg::div_rsp_t rsp_o
);
  import rdsa_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] num_q;
  logic [63:0] rem_q;
  logic [63:0] den_q;

  logic [64:0] sh;
  logic        ge;
  logic [64:0] diff;

  assign sh   = {rem_q, num_q[63]};
  assign ge   = sh >= {1'b0, den_q};
  assign diff = sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= req_i.num;
        den_q  <= req_i.den;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge ? diff[63:0] : sh[63:0];
        num_q <= {num_q[62:0], ge};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule
